// ----- src/bfd_pkg.sv -----
// Shared types and constants for the button frame decoder.
`timescale 1ns / 1ps

package bfd_pkg;

    // Sync byte that opens every frame.
    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    // Width of each button field on the result channel.
    localparam int FIELD_W = 14;

    // Width of the raw mask carried by a frame (low byte plus high byte).
    localparam int FRAME_MASK_W = 16;

    // Width of the packed result data, padded to whole bytes.
    localparam int OUT_DATA_W = 48;

    // Request kinds carried in tuser.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // Deframer phases.
    typedef enum logic [1:0] {
        PH_SYNC  = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2,
        PH_CHECK = 2'd3
    } frame_phase_t;

    // One result of a poll.
    typedef struct packed {
        logic [FIELD_W-1:0] released;
        logic [FIELD_W-1:0] pressed;
        logic               valid_res;
        logic [FIELD_W-1:0] mask;
    } poll_result_t;

endpackage

// ----- src/bfd_deframer.sv -----
// Byte deframer that loads the button mask from frames with a good checksum.
`timescale 1ns / 1ps

module bfd_deframer
    import bfd_pkg::*;
#(
    parameter int BUTTON_COUNT = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_strobe,
    input  logic [7:0]              rx_byte,
    output logic [BUTTON_COUNT-1:0] current_mask,
    output logic                    frame_seen
);

    frame_phase_t              phase_reg, phase_next;
    logic [7:0]                low_reg, low_next;
    logic [7:0]                high_reg, high_next;
    logic [BUTTON_COUNT-1:0]   mask_reg, mask_next;
    logic                      seen_reg, seen_next;
    logic [FRAME_MASK_W-1:0]   frame_mask;

    assign frame_mask = {high_reg, low_reg};

    // State registers of the deframer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC;
            low_reg   <= '0;
            high_reg  <= '0;
            mask_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            mask_reg  <= mask_next;
            seen_reg  <= seen_next;
        end
    end

    // Next phase and frame contents for each received byte.
    always_comb
    begin
        phase_next = phase_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mask_next  = mask_reg;
        seen_next  = seen_reg;
        if (byte_strobe)
        begin
            case (phase_reg)
                PH_SYNC:
                begin
                    if (rx_byte == SYNC_BYTE)
                    begin
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    low_next   = rx_byte;
                    phase_next = PH_HIGH;
                end
                PH_HIGH:
                begin
                    high_next  = rx_byte;
                    phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    // A bad checksum drops the frame and the deframer resyncs.
                    if (rx_byte == (SYNC_BYTE ^ low_reg ^ high_reg))
                    begin
                        mask_next = frame_mask[BUTTON_COUNT-1:0];
                        seen_next = 1'b1;
                    end
                    phase_next = PH_SYNC;
                end
                default:
                begin
                    phase_next = PH_SYNC;
                end
            endcase
        end
    end

    assign current_mask = mask_reg;
    assign frame_seen   = seen_reg;

endmodule

// ----- src/bfd_poll.sv -----
// Poll unit that reports the mask and the changes since the previous poll.
`timescale 1ns / 1ps

module bfd_poll
    import bfd_pkg::*;
#(
    parameter int BUTTON_COUNT = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    poll_strobe,
    input  logic [BUTTON_COUNT-1:0] current_mask,
    input  logic                    frame_seen,
    output poll_result_t            result
);

    logic [BUTTON_COUNT-1:0] polled_reg;
    logic                    seen_poll_reg;
    logic [BUTTON_COUNT-1:0] pressed_full;
    logic [BUTTON_COUNT-1:0] released_full;
    logic [FRAME_MASK_W-1:0] mask_wide;
    logic [FRAME_MASK_W-1:0] pressed_wide;
    logic [FRAME_MASK_W-1:0] released_wide;

    // Mask at the previous poll, and whether a poll has happened at all.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polled_reg    <= '0;
            seen_poll_reg <= 1'b0;
        end
        else if (poll_strobe)
        begin
            polled_reg    <= current_mask;
            seen_poll_reg <= 1'b1;
        end
    end

    // Edges against the previous poll; the first poll reports no changes.
    always_comb
    begin
        if (seen_poll_reg)
        begin
            pressed_full  = current_mask & ~polled_reg;
            released_full = polled_reg & ~current_mask;
        end
        else
        begin
            pressed_full  = '0;
            released_full = '0;
        end
    end

    // Widen to the frame mask width, then cut to the field width.
    assign mask_wide     = FRAME_MASK_W'(current_mask);
    assign pressed_wide  = FRAME_MASK_W'(pressed_full);
    assign released_wide = FRAME_MASK_W'(released_full);

    assign result.mask      = mask_wide[FIELD_W-1:0];
    assign result.valid_res = frame_seen;
    assign result.pressed   = pressed_wide[FIELD_W-1:0];
    assign result.released  = released_wide[FIELD_W-1:0];

endmodule

// ----- src/button_frame_decoder_top.sv -----
// Top level of the button frame decoder with input and result registers.
`timescale 1ns / 1ps

// Button frame decoder.
// The slave channel takes one request per cycle: tuser is the kind
// (0 = received serial byte in tdata, 1 = poll for the button state).
// Bytes run the deframer (sync 0xAA, low byte, high byte, XOR checksum)
// and give no result. Each poll gives one result on the master channel:
// current mask, valid flag, and the buttons pressed and released since
// the previous poll (both zero on the first poll after reset).
// A request is held in the input register and a poll is decoded on its
// way to the result register. One request is taken every cycle; the limit
// is the single result register, which a poll can only enter once the
// previous result has been taken or is being taken.
// When the receiver stalls, bytes keep flowing through the deframer; a
// poll waits in the input register and the slave side stalls behind it.
// Reset clears the deframer to wait for sync, clears the mask, the valid
// flag and the poll history, and empties both registers.
module button_frame_decoder_top
    import bfd_pkg::*;
#(
    parameter int BUTTON_COUNT = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // rx_byte[7:0]
    input  logic                  s_axis_tuser,   // func[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // mask[13:0], valid_res[14],
                                                  // pressed[28:15], released[42:29],
                                                  // zero pad[47:43]
);

    logic                    in_valid_reg;
    logic                    in_kind_reg;
    logic [7:0]              in_byte_reg;
    logic                    out_valid_reg;
    poll_result_t            out_data_reg;
    logic                    out_free;
    logic                    advance;
    logic                    byte_strobe;
    logic                    poll_strobe;
    logic [BUTTON_COUNT-1:0] current_mask;
    logic                    frame_seen;
    poll_result_t            poll_result;

    // Handshake between the input register and the result register.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && ((in_kind_reg == KIND_BYTE) || out_free);
    assign byte_strobe   = advance && (in_kind_reg == KIND_BYTE);
    assign poll_strobe   = advance && (in_kind_reg == KIND_POLL);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    bfd_deframer #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_deframer (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_strobe  (byte_strobe),
        .rx_byte      (in_byte_reg),
        .current_mask (current_mask),
        .frame_seen   (frame_seen)
    );

    bfd_poll #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_poll (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_strobe  (poll_strobe),
        .current_mask (current_mask),
        .frame_seen   (frame_seen),
        .result       (poll_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (poll_strobe)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_strobe)
        begin
            out_data_reg <= poll_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

endmodule
